// ----- design/battery_mv_to_state_of_charge_unit_macros.svh -----
// Assertion macros used by the checker file of the charge lookup unit.
`ifndef BATTERY_MV_TO_STATE_OF_CHARGE_UNIT_MACROS_SVH
`define BATTERY_MV_TO_STATE_OF_CHARGE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define BSOC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define BSOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/bsoc_pkg.sv -----
// Package with the widths, discharge curve tables and codes of the charge lookup unit.
package bsoc_pkg;

    // Field widths.
    localparam int MV_W   = 13;
    localparam int CHG_W  = 14;
    localparam int FLAG_W = 2;

    // Curve geometry.
    localparam int TABLE_POINTS     = 11;
    localparam int CURVE_POINTS_DEF = 11;
    localparam int FULL_SCALE       = 10000;
    localparam int SEG_W            = $clog2(TABLE_POINTS);
    localparam int STEP_W           = 14;

    // Datapath widths: the scaled offset magnitude stays below 2**26, and the
    // reciprocal holds floor(2**RECIP_SHIFT / span).
    localparam int MAG_W       = 26;
    localparam int RECIP_SHIFT = 27;
    localparam int REC_W       = 28;
    localparam int VAL_W       = 28;

    localparam logic [CHG_W-1:0] FULL_CHG = CHG_W'(FULL_SCALE);

    // Range flag codes.
    localparam logic [FLAG_W-1:0] FLAG_IN    = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_EMPTY = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_FULL  = 2'd2;

    // Lithium-polymer discharge curve, one point per 10 percent, in millivolts.
    localparam logic [MV_W-1:0] CURVE_MV [TABLE_POINTS] = '{
        13'd3300, 13'd3584, 13'd3678, 13'd3725, 13'd3748, 13'd3775,
        13'd3815, 13'd3873, 13'd3951, 13'd4036, 13'd4200
    };

    // Width of segment k in millivolts, point k minus point k-1 (entry 0 unused).
    localparam logic [MV_W-1:0] SPAN_MV [TABLE_POINTS] = '{
        13'd0, 13'd284, 13'd94, 13'd47, 13'd23, 13'd27,
        13'd40, 13'd58, 13'd78, 13'd85, 13'd164
    };

    // floor(2**27 / span) for segment k (entry 0 unused).
    localparam logic [REC_W-1:0] SPAN_RECIP [TABLE_POINTS] = '{
        28'd0,       28'd472597,  28'd1427848, 28'd2855696,
        28'd5835553, 28'd4971026, 28'd3355443, 28'd2314098,
        28'd1720740, 28'd1579032, 28'd818400
    };

endpackage

// ----- design/bsoc_ifs.sv -----
// Valid/ready channel interfaces for the voltage items and the charge result items.
interface bsoc_in_if;
    logic                     valid;
    logic                     ready;
    logic [bsoc_pkg::MV_W-1:0] battery_mv;

    modport source (output valid, output battery_mv, input ready);
    modport sink (input valid, input battery_mv, output ready);
endinterface

interface bsoc_out_if;
    logic                       valid;
    logic                       ready;
    logic [bsoc_pkg::CHG_W-1:0]  charge_centipercent;
    logic [bsoc_pkg::FLAG_W-1:0] range_flag;

    modport source (output valid, output charge_centipercent, output range_flag, input ready);
    modport sink (input valid, input charge_centipercent, input range_flag, output ready);
endinterface

// ----- design/battery_mv_to_state_of_charge_unit.sv -----
// Top level: pipelined piecewise-linear battery voltage to state-of-charge lookup.
//
//  Channel | Dir | Payload                                   | Handshake
//  i_in    | in  | battery_mv [12:0]                         | valid / ready
//  o_out   | out | charge_centipercent [13:0], range_flag [1:0] | valid / ready
//
// Six register stages: segment search, scale by the segment step, reciprocal
// multiply, back-multiply by the span, quotient correction, add and saturate.
// One item per cycle is accepted unless a stall at the output has filled every stage;
// an accepted item moves through the stage registers in order and is valid at the
// output once it reaches the last one.
// Reset (i_rst_n low at a clock edge) empties the pipeline and holds ready low.
// A stall at the output only holds back stages that are full; bubbles close up.
module battery_mv_to_state_of_charge_unit #(
    parameter int CURVE_POINTS = bsoc_pkg::CURVE_POINTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bsoc_in_if.sink         i_in,
    bsoc_out_if.source      o_out
);

    localparam int N_CLAMP = (CURVE_POINTS > bsoc_pkg::TABLE_POINTS) ?
                             bsoc_pkg::TABLE_POINTS : CURVE_POINTS;
    localparam int N_USED  = (N_CLAMP < 2) ? 2 : N_CLAMP;
    localparam int STEP_I  = bsoc_pkg::FULL_SCALE / (N_USED - 1);
    localparam int NUM_ST  = 6;

    localparam logic [bsoc_pkg::STEP_W-1:0] STEP     = bsoc_pkg::STEP_W'(STEP_I);
    localparam logic [bsoc_pkg::SEG_W-1:0]  LAST_SEG = bsoc_pkg::SEG_W'(N_USED - 1);
    localparam logic [bsoc_pkg::SEG_W-1:0]  SEG_ONE  = bsoc_pkg::SEG_W'(1);

    // Stage valid bits and per-stage load enables.
    logic [NUM_ST-1:0] r_vld;
    logic [NUM_ST-1:0] en;
    logic              in_acc;

    always_comb begin
        en[NUM_ST-1] = !r_vld[NUM_ST-1] || o_out.ready;
        for (int k = NUM_ST - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_in.ready = en[0] && i_rst_n;
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= in_acc;
            end
            for (int k = 1; k < NUM_ST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: first breakpoint at or above the voltage, offset and segment base.
    logic [bsoc_pkg::SEG_W-1:0]  n1_seg;
    logic [bsoc_pkg::SEG_W-1:0]  n1_seg_lo;
    logic signed [bsoc_pkg::MV_W:0] n1_diff;
    logic [bsoc_pkg::CHG_W-1:0]  n1_base;

    logic [bsoc_pkg::SEG_W-1:0]  r1_seg;
    logic signed [bsoc_pkg::MV_W:0] r1_diff;
    logic [bsoc_pkg::CHG_W-1:0]  r1_base;

    always_comb begin
        n1_seg = LAST_SEG;
        for (int k = N_USED - 1; k >= 1; k--) begin
            if (i_in.battery_mv <= bsoc_pkg::CURVE_MV[k]) begin
                n1_seg = bsoc_pkg::SEG_W'(k);
            end
        end
        n1_seg_lo = n1_seg - SEG_ONE;
        n1_diff   = $signed({1'b0, i_in.battery_mv}) -
                    $signed({1'b0, bsoc_pkg::CURVE_MV[n1_seg_lo]});
        n1_base   = bsoc_pkg::CHG_W'(n1_seg_lo * STEP);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_seg  <= n1_seg;
            r1_diff <= n1_diff;
            r1_base <= n1_base;
        end
    end

    // Stage 2: scale the offset by the segment step and split sign and magnitude.
    logic signed [bsoc_pkg::MV_W+bsoc_pkg::STEP_W+1:0] n2_prod;
    logic signed [bsoc_pkg::MV_W+bsoc_pkg::STEP_W+1:0] n2_abs;

    logic [bsoc_pkg::SEG_W-1:0]  r2_seg;
    logic                        r2_neg;
    logic [bsoc_pkg::MAG_W-1:0]  r2_mag;
    logic [bsoc_pkg::CHG_W-1:0]  r2_base;

    always_comb begin
        n2_prod = r1_diff * $signed({1'b0, STEP});
        n2_abs  = n2_prod[$bits(n2_prod)-1] ? -n2_prod : n2_prod;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_seg  <= r1_seg;
            r2_neg  <= n2_prod[$bits(n2_prod)-1];
            r2_mag  <= n2_abs[bsoc_pkg::MAG_W-1:0];
            r2_base <= r1_base;
        end
    end

    // Stage 3: quotient estimate by the span reciprocal, low by at most one.
    logic [bsoc_pkg::MAG_W+bsoc_pkg::REC_W-1:0] n3_prod;

    logic [bsoc_pkg::SEG_W-1:0]  r3_seg;
    logic                        r3_neg;
    logic [bsoc_pkg::MAG_W-1:0]  r3_mag;
    logic [bsoc_pkg::MAG_W-1:0]  r3_qe;
    logic [bsoc_pkg::CHG_W-1:0]  r3_base;

    assign n3_prod = r2_mag * bsoc_pkg::SPAN_RECIP[r2_seg];

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_seg  <= r2_seg;
            r3_neg  <= r2_neg;
            r3_mag  <= r2_mag;
            r3_qe   <= n3_prod[bsoc_pkg::RECIP_SHIFT +: bsoc_pkg::MAG_W];
            r3_base <= r2_base;
        end
    end

    // Stage 4: multiply the estimate back by the span.
    logic [bsoc_pkg::MAG_W+bsoc_pkg::MV_W-1:0] n4_prod;

    logic [bsoc_pkg::SEG_W-1:0]  r4_seg;
    logic                        r4_neg;
    logic [bsoc_pkg::MAG_W-1:0]  r4_mag;
    logic [bsoc_pkg::MAG_W-1:0]  r4_qe;
    logic [bsoc_pkg::MAG_W-1:0]  r4_qs;
    logic [bsoc_pkg::CHG_W-1:0]  r4_base;

    assign n4_prod = r3_qe * bsoc_pkg::SPAN_MV[r3_seg];

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_seg  <= r3_seg;
            r4_neg  <= r3_neg;
            r4_mag  <= r3_mag;
            r4_qe   <= r3_qe;
            r4_qs   <= n4_prod[bsoc_pkg::MAG_W-1:0];
            r4_base <= r3_base;
        end
    end

    // Stage 5: the remainder is below twice the span; one step fixes the quotient.
    logic [bsoc_pkg::MAG_W-1:0]  n5_rem;
    logic [bsoc_pkg::MAG_W-1:0]  n5_q;

    logic                        r5_neg;
    logic [bsoc_pkg::MAG_W-1:0]  r5_q;
    logic [bsoc_pkg::CHG_W-1:0]  r5_base;

    always_comb begin
        n5_rem = r4_mag - r4_qs;
        n5_q   = r4_qe;
        if (n5_rem >= bsoc_pkg::MAG_W'(bsoc_pkg::SPAN_MV[r4_seg])) begin
            n5_q = r4_qe + bsoc_pkg::MAG_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r5_neg  <= r4_neg;
            r5_q    <= n5_q;
            r5_base <= r4_base;
        end
    end

    // Stage 6: add the segment base, saturate and flag the clamp direction.
    logic signed [bsoc_pkg::VAL_W-1:0] n6_off;
    logic signed [bsoc_pkg::VAL_W-1:0] n6_val;
    logic [bsoc_pkg::CHG_W-1:0]        n6_chg;
    logic [bsoc_pkg::FLAG_W-1:0]       n6_flag;

    logic [bsoc_pkg::CHG_W-1:0]  r6_chg;
    logic [bsoc_pkg::FLAG_W-1:0] r6_flag;

    always_comb begin
        n6_off = $signed({{(bsoc_pkg::VAL_W-bsoc_pkg::MAG_W){1'b0}}, r5_q});
        if (r5_neg) begin
            n6_off = -n6_off;
        end
        n6_val = $signed({{(bsoc_pkg::VAL_W-bsoc_pkg::CHG_W){1'b0}}, r5_base}) + n6_off;
        if (n6_val < 0) begin
            n6_chg  = '0;
            n6_flag = bsoc_pkg::FLAG_EMPTY;
        end else if (n6_val > bsoc_pkg::VAL_W'(bsoc_pkg::FULL_SCALE)) begin
            n6_chg  = bsoc_pkg::FULL_CHG;
            n6_flag = bsoc_pkg::FLAG_FULL;
        end else begin
            n6_chg  = n6_val[bsoc_pkg::CHG_W-1:0];
            n6_flag = bsoc_pkg::FLAG_IN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r6_chg  <= n6_chg;
            r6_flag <= n6_flag;
        end
    end

    assign o_out.valid               = r_vld[NUM_ST-1];
    assign o_out.charge_centipercent = r6_chg;
    assign o_out.range_flag          = r6_flag;

endmodule

// ----- design/bsoc_chk.sv -----
// Port-level checker for the charge lookup unit, with its bind statement.
`include "battery_mv_to_state_of_charge_unit_macros.svh"

module bsoc_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [bsoc_pkg::CHG_W-1:0]  i_chg,
    input logic [bsoc_pkg::FLAG_W-1:0] i_flag
);

    logic                                       in_acc;
    logic                                       out_stall;
    logic                                       flag_ok;
    logic [bsoc_pkg::CHG_W+bsoc_pkg::FLAG_W-1:0] out_word;

    assign in_acc    = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;
    assign out_word  = {i_chg, i_flag};
    assign flag_ok   = (i_flag == bsoc_pkg::FLAG_IN) ||
                       ((i_flag == bsoc_pkg::FLAG_EMPTY) && (i_chg == '0)) ||
                       ((i_flag == bsoc_pkg::FLAG_FULL) && (i_chg == bsoc_pkg::FULL_CHG));

    // A result never exceeds full charge.
    `BSOC_ASSERT_IMPL(a_chg_range, i_out_valid, i_chg <= bsoc_pkg::FULL_CHG, "charge above full")

    // A clamp flag always comes with the matching end value, and no other code appears.
    `BSOC_ASSERT_IMPL(a_flag_value, i_out_valid, flag_ok, "range flag disagrees with charge")

    // A result held back by the sink keeps its value.
    `BSOC_ASSERT_NEXT(a_out_hold, out_stall, i_out_valid && $stable(out_word), "held result changed")

    // With the sink ready throughout, an accepted item is valid at the output after passing every stage.
    `BSOC_ASSERT_NEXT(a_latency, in_acc ##1 i_out_ready [*5], i_out_valid, "result late")

endmodule

bind battery_mv_to_state_of_charge_unit bsoc_chk u_bsoc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_chg       (o_out.charge_centipercent),
    .i_flag      (o_out.range_flag)
);
